>>> design/ebml_element_header_encoder_macros.svh
// Assertion shorthands for the element header encoder checks.
// Both expect clk and arst_n in scope.
`ifndef EBML_ELEMENT_HEADER_ENCODER_MACROS_SVH
`define EBML_ELEMENT_HEADER_ENCODER_MACROS_SVH

`define EHE_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define EHE_ASSERT(lbl, prop) \
	`EHE_ASSERT_MSG(lbl, prop, "ebml header encoder check failed")

`endif

>>> design/ebhe_pkg.sv
package ebhe_pkg;

	localparam int unsigned VINT_MAX_BYTES = 8;
	localparam int unsigned VINT_BITS      = 7;
	localparam int unsigned VINT_MAX_BITS  = 56;
	localparam int unsigned SAT_VINT_BITS  = 49;
	localparam logic [63:0] LEN_LIMIT      = (64'd1 << VINT_MAX_BITS) - 64'd2;
	localparam logic [7:0]  SIZE_MARK      = 8'h80;

	localparam logic OP_UINT   = 1'b0;
	localparam logic OP_HEADER = 1'b1;

	// One classified element, ready to serialize: class ID bytes, an optional
	// size byte, then the body bytes. Counts are stored minus one.
	typedef struct packed {
		logic [31:0] cid;
		logic [1:0]  cid_m1;
		logic        has_hdr;
		logic [7:0]  hdr;
		logic [63:0] body;
		logic [2:0]  body_m1;
	} desc_t;

	typedef enum logic [1:0] {
		PH_CID,
		PH_HDR,
		PH_BODY
	} phase_t;

endpackage

>>> design/ebhe_front.sv
module ebhe_front (
	input  logic            op,
	input  logic [31:0]     class_id,
	input  logic [63:0]     value,
	input  logic [3:0]      width,
	output ebhe_pkg::desc_t desc
);
	import ebhe_pkg::*;

	logic [1:0]  cid_m1;
	logic [2:0]  val_m1;
	logic [2:0]  w_m1;
	logic [3:0]  w_dec;
	logic [3:0]  w_eff;
	logic [63:0] len;
	logic [2:0]  len_m1;
	logic [63:0] len_vint;

	assign w_dec = width - 4'd1;

	always_comb begin
		cid_m1 = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (class_id[8*i +: 8] != 8'd0)
				cid_m1 = i[1:0];
		end

		val_m1 = 3'd0;
		for (int i = 1; i < VINT_MAX_BYTES; i++) begin
			if (value[8*i +: 8] != 8'd0)
				val_m1 = i[2:0];
		end

		if (width == 4'd0)
			w_m1 = val_m1;
		else if (width > 4'd8)
			w_m1 = 3'd7;
		else
			w_m1 = w_dec[2:0];
		w_eff = {1'b0, w_m1} + 4'd1;

		// saturate, then pick the shortest vint that avoids the all-ones code
		len = (value > LEN_LIMIT) ? LEN_LIMIT : value;
		len_m1 = 3'd7;
		if (len <= (64'd1 << SAT_VINT_BITS) - 64'd2)
			len_m1 = 3'd6;
		for (int i = 5; i >= 0; i--) begin
			if (len <= (64'd1 << (VINT_BITS * (i + 1))) - 64'd2)
				len_m1 = i[2:0];
		end
		len_vint = len;
		for (int i = 0; i < VINT_MAX_BYTES; i++) begin
			if (len_m1 == i[2:0])
				len_vint[VINT_BITS * (i + 1)] = 1'b1;
		end

		desc.cid    = class_id;
		desc.cid_m1 = cid_m1;
		if (op == OP_HEADER) begin
			desc.has_hdr = 1'b0;
			desc.hdr     = SIZE_MARK;
			desc.body    = len_vint;
			desc.body_m1 = len_m1;
		end else begin
			desc.has_hdr = 1'b1;
			desc.hdr     = SIZE_MARK | {4'd0, w_eff};
			desc.body    = value;
			desc.body_m1 = w_m1;
		end
	end

endmodule

>>> design/ebhe_fifo.sv
module ebhe_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  ebhe_pkg::desc_t wdata,
	output logic            full,
	input  logic            rd,
	output ebhe_pkg::desc_t rdata,
	output logic            empty
);
	import ebhe_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

>>> design/ebhe_back.sv
module ebhe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  ebhe_pkg::desc_t q_rdata,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [7:0]      out_byte,
	output logic            last
);
	import ebhe_pkg::*;

	desc_t      desc_q;
	logic       cur_v_q;
	phase_t     phase_q;
	phase_t     phase_d;
	logic [2:0] cnt_q;
	logic [2:0] cnt_d;
	logic       cur_v_d;
	logic       oval_q;
	logic [7:0] obyte_q;
	logic       olast_q;
	logic       adv;
	logic       emit;
	logic       load;
	logic [7:0] cur_byte;
	logic       cur_last;

	assign adv  = !oval_q || pop;
	assign emit = cur_v_q && adv;

	always_comb begin
		case (phase_q)
			PH_CID:  cur_byte = desc_q.cid[{cnt_q[1:0], 3'b000} +: 8];
			PH_HDR:  cur_byte = desc_q.hdr;
			PH_BODY: cur_byte = desc_q.body[{cnt_q, 3'b000} +: 8];
			default: cur_byte = 8'd0;
		endcase
		cur_last = (phase_q == PH_BODY) && (cnt_q == 3'd0);
		load     = !q_empty && (!cur_v_q || (emit && cur_last));

		phase_d = phase_q;
		cnt_d   = cnt_q;
		cur_v_d = cur_v_q;
		if (load) begin
			phase_d = PH_CID;
			cnt_d   = {1'b0, q_rdata.cid_m1};
			cur_v_d = 1'b1;
		end else if (emit) begin
			case (phase_q)
				PH_CID: begin
					if (cnt_q != 3'd0) begin
						cnt_d = cnt_q - 3'd1;
					end else if (desc_q.has_hdr) begin
						phase_d = PH_HDR;
					end else begin
						phase_d = PH_BODY;
						cnt_d   = desc_q.body_m1;
					end
				end
				PH_HDR: begin
					phase_d = PH_BODY;
					cnt_d   = desc_q.body_m1;
				end
				PH_BODY: begin
					if (cnt_q != 3'd0)
						cnt_d = cnt_q - 3'd1;
					else
						cur_v_d = 1'b0;
				end
				default: begin
					phase_d = PH_CID;
					cur_v_d = 1'b0;
				end
			endcase
		end
	end

	assign q_pop    = load;
	assign empty    = !oval_q;
	assign out_byte = obyte_q;
	assign last     = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CID;
			cnt_q   <= 3'd0;
			cur_v_q <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			cur_v_q <= cur_v_d;
			if (emit)
				oval_q <= 1'b1;
			else if (pop)
				oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			desc_q <= q_rdata;
		if (emit) begin
			obyte_q <= cur_byte;
			olast_q <= cur_last;
		end
	end

endmodule

>>> design/ebml_element_header_encoder.sv
// EBML element header encoder.
// Input queue side: drive op, class_id, value and width with push; the item
// is taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low, out_byte and last show the oldest
// byte; it is taken on a clock edge where pop is high. Bytes come out most
// significant first: the trimmed class ID (1 to 4 bytes), then for op 0 a
// size byte and the value (1 to 8 bytes), for op 1 a length vint (1 to 8
// bytes). last marks the final byte of each item.
// The first byte of an item passes through the queue, the serializer's current
// item register and the output register before it shows on the result ports.
// Throughput: one byte per cycle from the serializer while the receiver pops;
// an item is 2 to 13 bytes long, and queued items follow each other with no gap.
// A queue of QUEUE_DEPTH classified items sits between the classifier and
// the serializer, so pushes keep landing while a long item drains.
// When the receiver stalls, the output register holds its byte and the
// queue fills; full rises once it holds QUEUE_DEPTH items.
// Reset empties the queue, the serializer's current item and the output register.
module ebml_element_header_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [31:0] class_id,
	input  logic [63:0] value,
	input  logic [3:0]  width,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last
);
	import ebhe_pkg::*;

	desc_t front_desc;
	desc_t q_rdata;
	logic  q_empty;
	logic  q_pop;

	ebhe_front u_front (
		.op       (op),
		.class_id (class_id),
		.value    (value),
		.width    (width),
		.desc     (front_desc)
	);

	ebhe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (front_desc),
		.full   (full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	ebhe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

>>> design/ebhe_checker.sv
`include "ebml_element_header_encoder_macros.svh"

module ebhe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       last
);

	logic [3:0] bytes_q;
	logic [7:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;
	logic       item_done;

	assign in_xfer   = push && !full;
	assign out_xfer  = pop && !empty;
	assign item_done = out_xfer && last;

	// count bytes within the current item and items not yet fully delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= 4'd0;
			pend_q  <= 8'd0;
		end else begin
			if (out_xfer)
				bytes_q <= last ? 4'd0 : bytes_q + 4'd1;
			if (in_xfer && !item_done)
				pend_q <= pend_q + 8'd1;
			else if (item_done && !in_xfer)
				pend_q <= pend_q - 8'd1;
		end
	end

	`EHE_ASSERT_MSG(a_hold_stall, (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)), "result changed under stall")
	`EHE_ASSERT_MSG(a_max_len, (!empty && bytes_q == 4'd12) |-> last, "item longer than 13 bytes")
	`EHE_ASSERT(a_min_len, (!empty && last) |-> (bytes_q != 4'd0))
	`EHE_ASSERT_MSG(a_no_orphan, !empty |-> (pend_q != 8'd0), "result with no item pending")

endmodule

bind ebml_element_header_encoder ebhe_checker u_ebhe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_byte (out_byte),
	.last     (last)
);

>>> tb/ebml_element_header_encoder_tb.sv
module ebml_element_header_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ebhe_pkg::*;

	typedef struct packed {
		logic        op;
		logic [31:0] cid;
		logic [63:0] val;
		logic [3:0]  w;
		logic [3:0]  n_typed;   // 0: take the bytes from the encoder model
		logic [103:0] typed;    // typed bytes, first byte most significant
	} element_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} out_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        op = OP_UINT;
	logic [31:0] class_id = '0;
	logic [63:0] value = '0;
	logic [3:0]  width = '0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  out_byte;
	logic        last;

	out_beat_t    expected_bytes[$];
	element_row_t dir_rows[$];
	int           mismatches = 0;
	int           items_sent = 0;
	int           bytes_seen = 0;
	int           pop_stall = 0;
	bit           steady = 1'b0;

	ebml_element_header_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.class_id (class_id),
		.value    (value),
		.width    (width),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.last     (last)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int sig_bytes(input logic [63:0] v);
		int n;
		n = 1;
		while (n < VINT_MAX_BYTES && (v >> (8 * n)) != 64'd0)
			n = n + 1;
		return n;
	endfunction

	// Queue one expected byte at the tail.
	function automatic void append_beat(input logic [7:0] d, input logic l);
		out_beat_t b;
		b.data    = d;
		b.is_last = l;
		expected_bytes = {expected_bytes, b};
	endfunction

	// Serialize one element the way the encoder should and queue its bytes.
	function automatic void encode_element(input element_row_t r);
		logic [7:0]  seq [13];
		logic [63:0] v;
		int          k;
		int          nb;
		int          i;
		k = 0;
		nb = sig_bytes({32'd0, r.cid});
		for (i = nb - 1; i >= 0; i--) begin
			seq[k] = r.cid[8 * i +: 8];
			k = k + 1;
		end
		if (r.op == OP_UINT) begin
			if (r.w == 4'd0)
				nb = sig_bytes(r.val);
			else if (r.w > VINT_MAX_BYTES)
				nb = VINT_MAX_BYTES;
			else
				nb = int'(r.w);
			seq[k] = SIZE_MARK | 8'(nb);
			k = k + 1;
			v = r.val;
		end else begin
			v = (r.val > LEN_LIMIT) ? LEN_LIMIT : r.val;
			nb = 1;
			// skip the all-ones pattern reserved for unknown length
			while (nb < VINT_MAX_BYTES && v > ((64'd1 << (VINT_BITS * nb)) - 64'd2))
				nb = nb + 1;
			v = v | (64'd1 << (VINT_BITS * nb));
		end
		for (i = nb - 1; i >= 0; i--) begin
			seq[k] = v[8 * i +: 8];
			k = k + 1;
		end
		for (i = 0; i < k; i++)
			append_beat(seq[i], i == k - 1);
	endfunction

	task automatic add_row(input logic o, input logic [31:0] c, input logic [63:0] v,
			input logic [3:0] w, input logic [3:0] n, input logic [103:0] t);
		element_row_t row;
		row.op      = o;
		row.cid     = c;
		row.val     = v;
		row.w       = w;
		row.n_typed = n;
		row.typed   = t;
		dir_rows = {dir_rows, row};
	endtask

	// Entered and left at a falling edge; push changes once per edge.
	task automatic send_item(input element_row_t r);
		int gap;
		int i;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push     <= 1'b1;
		op       <= r.op;
		class_id <= r.cid;
		value    <= r.val;
		width    <= r.w;
		do
			@(posedge clk);
		while (full);
		if (r.n_typed != 4'd0) begin
			for (i = 0; i < r.n_typed; i++)
				append_beat(r.typed[8 * (r.n_typed - 1 - i) +: 8], i == r.n_typed - 1);
		end else begin
			encode_element(r);
		end
		items_sent = items_sent + 1;
		@(negedge clk);
	endtask

	function automatic element_row_t random_row();
		element_row_t r;
		int           n;
		r.op = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0)
			r.cid = 32'd0;
		else
			r.cid = $urandom >> (8 * $urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: r.val = {$urandom, $urandom} >> (8 * $urandom_range(0, 7));
			1: begin
				n = $urandom_range(1, 8);
				// land around the top of an n-byte length
				r.val = (64'd1 << (VINT_BITS * n)) - 64'd3 + 64'($urandom_range(0, 3));
			end
			2: r.val = {$urandom, $urandom};
			default: r.val = 64'($urandom_range(0, 300));
		endcase
		n = $urandom_range(0, 9);
		if (n < 5)
			r.w = 4'd0;
		else if (n < 9)
			r.w = 4'($urandom_range(1, 8));
		else
			r.w = 4'($urandom_range(9, 15));
		r.n_typed = 4'd0;
		r.typed = '0;
		return r;
	endfunction

	always @(negedge clk) begin
		int gap;
		if (arst_n) begin
			if (pop_stall > 0) begin
				pop <= 1'b0;
				pop_stall = pop_stall - 1;
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					pop <= 1'b1;
				end else begin
					pop <= 1'b0;
					pop_stall = gap - 1;
				end
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		mismatches = mismatches + 1;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, exp_v,
				act_v);
	endtask

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && pop && !empty) begin
			bytes_seen = bytes_seen + 1;
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected transfer, out_byte", 8'h00, out_byte);
			end else begin
				e = expected_bytes.pop_front();
				if (out_byte !== e.data)
					report_mismatch("out_byte", e.data, out_byte);
				if (last !== e.is_last)
					report_mismatch("last", {7'd0, e.is_last}, {7'd0, last});
			end
		end
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		element_row_t r;
		int           i;

		add_row(OP_UINT, 32'h0, 64'h0, 4'd0, 4'd3, 104'h008100);
		add_row(OP_UINT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 4'd13,
			{32'hFFFF_FFFF, 8'h88, 64'hFFFF_FFFF_FFFF_FFFF});
		add_row(OP_UINT, 32'h1A45_DFA3, 64'd5, 4'd0, 4'd6, 104'h1A45_DFA3_8105);
		add_row(OP_UINT, 32'hEC, 64'h1234, 4'd1, 4'd3, 104'hEC8134);
		add_row(OP_HEADER, 32'h1853_8067, 64'd0, 4'd0, 4'd5, 104'h1853_8067_80);
		add_row(OP_HEADER, 32'hA3, 64'd126, 4'd0, 4'd2, 104'hA3FE);
		add_row(OP_HEADER, 32'h1F43_B675, LEN_LIMIT, 4'd0, 4'd12,
			104'h1F43_B675_01FF_FFFF_FFFF_FFFE);
		add_row(OP_HEADER, 32'h1F43_B675, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 4'd12,
			104'h1F43_B675_01FF_FFFF_FFFF_FFFE);
		add_row(OP_UINT, 32'h4286, 64'h0102_0304_0506_0708, 4'd15, 4'd0, '0);
		add_row(OP_UINT, 32'h4287, 64'd1, 4'd8, 4'd0, '0);
		add_row(OP_UINT, 32'h4285, 64'hABCD, 4'd9, 4'd0, '0);
		add_row(OP_UINT, 32'hD7, 64'hAABB_CCDD_EEFF, 4'd3, 4'd0, '0);
		add_row(OP_UINT, 32'h0001_0000, 64'h0100_0000_0000_0000, 4'd0, 4'd0, '0);
		add_row(OP_UINT, 32'hFF, 64'h8000_0000_0000_0000, 4'd0, 4'd0, '0);
		add_row(OP_HEADER, 32'h1654_AE6B, 64'd127, 4'd0, 4'd0, '0);
		add_row(OP_HEADER, 32'hAE, 64'd16382, 4'd0, 4'd0, '0);
		add_row(OP_HEADER, 32'hAE, 64'd16383, 4'd0, 4'd0, '0);
		add_row(OP_HEADER, 32'h1F43_B675, (64'd1 << 49) - 64'd2, 4'd0, 4'd0, '0);
		add_row(OP_HEADER, 32'h1F43_B675, (64'd1 << 49) - 64'd1, 4'd0, 4'd0, '0);
		add_row(OP_HEADER, 32'h1A45_DFA3, (64'd1 << 56) - 64'd1, 4'd0, 4'd0, '0);
		add_row(OP_HEADER, 32'h0, 64'd300, 4'd15, 4'd0, '0);
		add_row(OP_HEADER, 32'h80, 64'd1, 4'd5, 4'd0, '0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i]);

		// hold off until the encoder has drained completely
		push <= 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);

		for (i = 0; i < 220; i++) begin
			steady = (i >= 90 && i < 130);
			if (i == 150) begin
				push <= 1'b0;
				while (expected_bytes.size() != 0)
					@(negedge clk);
			end
			r = random_row();
			send_item(r);
		end
		steady = 1'b0;
		push <= 1'b0;

		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_bytes.size() != 0)
			mismatches = mismatches + 1;

		$display("Encoded %0d elements (directed and random, both ops) into %0d bytes",
			items_sent, bytes_seen);
		$display("with random gaps on push and pop; %0d mismatches", mismatches);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
